// ===== design/rst_pkg.sv =====
`default_nettype none
package rst_pkg;
  localparam int NUM_STATIONS = 8;
  localparam int ROB_ENTRIES  = 16;
  localparam int DATA_WIDTH   = 32;

  typedef enum logic [2:0] {
    OP_DISPATCH  = 3'd0,
    OP_BROADCAST = 3'd1,
    OP_SELECT    = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_EXECUTE   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOTAG = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_step;
  } ctrl_t;

  typedef struct packed {
    logic scan_end;
  } stat_t;
endpackage
`default_nettype wire

// ===== design/rst_ctrl.sv =====
`default_nettype none
module rst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [2:0]    operation,
  input  wire rst_pkg::stat_t stat,
  output rst_pkg::ctrl_t     ctrl,
  output logic               busy
);
  import rst_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load = 1'b1;
          state_next = (operation == OP_SELECT) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_end) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    ctrl.scan_start = ctrl.load && (operation == OP_SELECT);
  end
endmodule
`default_nettype wire

// ===== design/rst_dp.sv =====
`default_nettype none
module rst_dp (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rst_pkg::ctrl_t ctrl,
  output rst_pkg::stat_t   stat,
  input  wire logic [2:0]  operation,
  input  wire logic [7:0]  instr_tag,
  input  wire logic signed [31:0] src1_value,
  input  wire logic signed [31:0] src2_value,
  input  wire logic        src1_waiting,
  input  wire logic [3:0]  src1_tag,
  input  wire logic        src2_waiting,
  input  wire logic [3:0]  src2_tag,
  input  wire logic [3:0]  rob_tag,
  input  wire logic [15:0] cycle_now,
  input  wire logic [7:0]  exec_cycles,
  input  wire logic signed [31:0] bus_value,
  output logic             done,
  output logic [1:0]       status,
  output logic [2:0]       slot,
  output logic [7:0]       sel_instr_tag,
  output logic signed [31:0] sel_src1,
  output logic signed [31:0] sel_src2,
  output logic [3:0]       sel_rob_tag,
  output logic             last
);
  import rst_pkg::*;
  localparam int IW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
  localparam int CW = $clog2(NUM_STATIONS + 1);

  logic [NUM_STATIONS-1:0] busy_q;
  logic [7:0]  e_instr [NUM_STATIONS];
  logic [DATA_WIDTH-1:0] e_v1 [NUM_STATIONS];
  logic [DATA_WIDTH-1:0] e_v2 [NUM_STATIONS];
  logic [NUM_STATIONS-1:0] e_w1, e_w2;
  logic [3:0]  e_t1 [NUM_STATIONS];
  logic [3:0]  e_t2 [NUM_STATIONS];
  logic [3:0]  e_rob [NUM_STATIONS];
  logic [15:0] e_cyc [NUM_STATIONS];
  logic [7:0]  e_left [NUM_STATIONS];
  logic [CW-1:0] used;

  logic [2:0]  op_q;
  logic [7:0]  it_q, ec_q;
  logic [31:0] v1_q, v2_q, bv_q;
  logic        w1_q, w2_q;
  logic [3:0]  t1_q, t2_q, tag_q;
  logic [15:0] now_q;

  logic [CW-1:0] idx;
  logic          found_any;
  logic [NUM_STATIONS-1:0] ready, hit, rest;
  logic [IW-1:0] hit_pos;
  logic          hit_ok;
  logic          sel_hit;
  logic [DATA_WIDTH-1:0] bvw;

  assign bvw = DATA_WIDTH'(bv_q);

  always_comb begin
    for (int i = 0; i < NUM_STATIONS; i++) begin
      ready[i] = busy_q[i] && !e_w1[i] && !e_w2[i] && (e_cyc[i] < now_q)
                 && (e_left[i] != 8'd0);
      hit[i] = busy_q[i] && (e_rob[i] == tag_q) && (CW'(i) < used);
      rest[i] = ready[i] && (CW'(i) > idx);
    end
    hit_ok = |hit;
    hit_pos = '0;
    for (int i = NUM_STATIONS - 1; i >= 0; i--) if (hit[i]) hit_pos = IW'(i);
  end

  assign sel_hit = ready[idx[IW-1:0]] && (idx < used);
  assign stat.scan_end = (idx >= CW'(NUM_STATIONS - 1)) || !(|rest);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_q <= operation; it_q <= instr_tag; ec_q <= exec_cycles;
      v1_q <= src1_value; v2_q <= src2_value; bv_q <= bus_value;
      w1_q <= src1_waiting; w2_q <= src2_waiting;
      t1_q <= src1_tag; t2_q <= src2_tag; tag_q <= rob_tag; now_q <= cycle_now;
    end
    if (ctrl.scan_start) idx <= '0;
    else if (ctrl.scan_step) idx <= idx + 1'b1;
    if (ctrl.exec) begin
      unique case (op_q)
        OP_DISPATCH: if (used < CW'(NUM_STATIONS)) begin
          e_instr[used[IW-1:0]] <= it_q;
          e_v1[used[IW-1:0]] <= DATA_WIDTH'(v1_q);
          e_v2[used[IW-1:0]] <= DATA_WIDTH'(v2_q);
          e_w1[used[IW-1:0]] <= w1_q; e_w2[used[IW-1:0]] <= w2_q;
          e_t1[used[IW-1:0]] <= t1_q; e_t2[used[IW-1:0]] <= t2_q;
          e_rob[used[IW-1:0]] <= tag_q; e_cyc[used[IW-1:0]] <= now_q;
          e_left[used[IW-1:0]] <= ec_q;
        end
        OP_BROADCAST: for (int i = 0; i < NUM_STATIONS; i++) begin
          if (busy_q[i] && e_w1[i] && e_t1[i] == tag_q) begin
            e_v1[i] <= bvw; e_w1[i] <= 1'b0;
          end
          if (busy_q[i] && e_w2[i] && e_t2[i] == tag_q) begin
            e_v2[i] <= bvw; e_w2[i] <= 1'b0;
          end
        end
        OP_REMOVE: if (hit_ok) begin
          for (int i = 0; i < NUM_STATIONS - 1; i++) if (IW'(i) >= hit_pos) begin
            e_instr[i] <= e_instr[i+1]; e_v1[i] <= e_v1[i+1]; e_v2[i] <= e_v2[i+1];
            e_w1[i] <= e_w1[i+1]; e_w2[i] <= e_w2[i+1];
            e_t1[i] <= e_t1[i+1]; e_t2[i] <= e_t2[i+1];
            e_rob[i] <= e_rob[i+1]; e_cyc[i] <= e_cyc[i+1]; e_left[i] <= e_left[i+1];
          end
        end
        OP_EXECUTE: if (hit_ok && e_left[hit_pos] != 8'd0)
          e_left[hit_pos] <= e_left[hit_pos] - 8'd1;
        default: ;
      endcase
    end
    if (rst) begin
      busy_q <= '0; used <= '0;
    end else if (ctrl.exec) begin
      if (op_q == OP_DISPATCH && used < CW'(NUM_STATIONS)) begin
        busy_q[used[IW-1:0]] <= 1'b1; used <= used + 1'b1;
      end else if (op_q == OP_REMOVE && hit_ok) begin
        busy_q[used[IW-1:0] - 1'b1] <= 1'b0; used <= used - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0; found_any <= 1'b0;
    end else begin
      done <= ctrl.exec || (ctrl.scan_step && (sel_hit || (stat.scan_end && !found_any)));
      if (ctrl.scan_start) found_any <= 1'b0;
      else if (ctrl.scan_step && sel_hit) found_any <= 1'b1;
      if (ctrl.exec) begin
        last <= 1'b1;
        if (op_q == OP_DISPATCH && used >= CW'(NUM_STATIONS)) status <= ST_FULL;
        else if ((op_q == OP_REMOVE || op_q == OP_EXECUTE) && !hit_ok) status <= ST_NOTAG;
        else status <= ST_OK;
        if (op_q == OP_DISPATCH && used < CW'(NUM_STATIONS)) slot <= 3'(used);
        else if ((op_q == OP_REMOVE || op_q == OP_EXECUTE) && hit_ok) slot <= 3'(hit_pos);
        else slot <= '0;
        sel_instr_tag <= '0; sel_src1 <= '0; sel_src2 <= '0; sel_rob_tag <= '0;
      end else if (ctrl.scan_step) begin
        if (sel_hit) begin
          status <= ST_OK; slot <= 3'(idx);
          sel_instr_tag <= e_instr[idx[IW-1:0]];
          sel_src1 <= 32'(e_v1[idx[IW-1:0]]);
          sel_src2 <= 32'(e_v2[idx[IW-1:0]]);
          sel_rob_tag <= e_rob[idx[IW-1:0]];
          last <= stat.scan_end;
        end else if (stat.scan_end && !found_any) begin
          status <= ST_NONE; slot <= '0; last <= 1'b1;
          sel_instr_tag <= '0; sel_src1 <= '0; sel_src2 <= '0; sel_rob_tag <= '0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/reservation_station_table_core.sv =====
// Reservation station table kept in dispatch order.
// An operation beat is taken at a clock edge with start high and busy low.
// Dispatch, broadcast, remove and execute (and any unused operation code) each
// pass through the EXEC state and show one result beat registered from it, and
// the next start beat can be taken at the edge that ends the cycle of that beat.
// Select scans the table one entry a cycle through a single scan counter and
// emits one beat per ready entry, oldest first, or one beat with status
// "nothing ready"; a select keeps the block busy through the SCAN and DONE
// states. Each result beat is shown for one cycle with done high and last
// marks the final beat of an operation. The receiver cannot stall.
// Synchronous reset empties the table and returns the controller to idle.
`default_nettype none
module reservation_station_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [7:0]  instr_tag,
  input  wire logic signed [31:0] src1_value,
  input  wire logic signed [31:0] src2_value,
  input  wire logic        src1_waiting,
  input  wire logic [3:0]  src1_tag,
  input  wire logic        src2_waiting,
  input  wire logic [3:0]  src2_tag,
  input  wire logic [3:0]  rob_tag,
  input  wire logic [15:0] cycle_now,
  input  wire logic [7:0]  exec_cycles,
  input  wire logic signed [31:0] bus_value,
  output logic             done,
  output logic [1:0]       status,
  output logic [2:0]       slot,
  output logic [7:0]       sel_instr_tag,
  output logic signed [31:0] sel_src1,
  output logic signed [31:0] sel_src2,
  output logic [3:0]       sel_rob_tag,
  output logic             last
);
  import rst_pkg::*;
  ctrl_t ctrl;
  stat_t stat;

  rst_ctrl u_ctrl (.clk, .rst, .start, .operation, .stat, .ctrl, .busy);

  rst_dp u_dp (
    .clk, .rst, .ctrl, .stat, .operation, .instr_tag, .src1_value, .src2_value,
    .src1_waiting, .src1_tag, .src2_waiting, .src2_tag, .rob_tag, .cycle_now,
    .exec_cycles, .bus_value, .done, .status, .slot, .sel_instr_tag,
    .sel_src1, .sel_src2, .sel_rob_tag, .last);
endmodule
`default_nettype wire

// ===== design/rst_checker.sv =====
`default_nettype none
module rst_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic last,
  input wire logic [1:0] status
);
  import rst_pkg::*;
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy low after start beat");
  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> busy || last) else $error("result beat outside operation");
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_NONE |-> last) else $error("nothing ready not last");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !done) else $error("result beat after reset");
endmodule
bind reservation_station_table_core rst_checker u_chk (.clk, .rst, .start, .busy,
  .done, .last, .status);
`default_nettype wire

// ===== tb/reservation_station_table_core_tb.sv =====
`default_nettype none
module reservation_station_table_core_tb;
  import rst_pkg::*;

  localparam int NSTAT = 8;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [7:0]  instr;
    logic [31:0] src1;
    logic [31:0] src2;
    logic [3:0]  rob;
    logic        last;
  } beat_t;

  typedef struct {
    logic [7:0]  instr;
    logic [31:0] val1;
    logic [31:0] val2;
    logic        wait1;
    logic [3:0]  tag1;
    logic        wait2;
    logic [3:0]  tag2;
    logic [3:0]  rob;
    logic [15:0] cyc;
    logic [7:0]  left;
  } station_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] operation = '0;
  logic [7:0] instr_tag = '0;
  logic signed [31:0] src1_value = '0;
  logic signed [31:0] src2_value = '0;
  logic src1_waiting = 1'b0;
  logic [3:0] src1_tag = '0;
  logic src2_waiting = 1'b0;
  logic [3:0] src2_tag = '0;
  logic [3:0] rob_tag = '0;
  logic [15:0] cycle_now = '0;
  logic [7:0] exec_cycles = '0;
  logic signed [31:0] bus_value = '0;
  logic done;
  logic [1:0] status;
  logic [2:0] slot;
  logic [7:0] sel_instr_tag;
  logic signed [31:0] sel_src1;
  logic signed [31:0] sel_src2;
  logic [3:0] sel_rob_tag;
  logic last;

  reservation_station_table_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .instr_tag(instr_tag), .src1_value(src1_value), .src2_value(src2_value),
    .src1_waiting(src1_waiting), .src1_tag(src1_tag), .src2_waiting(src2_waiting),
    .src2_tag(src2_tag), .rob_tag(rob_tag), .cycle_now(cycle_now),
    .exec_cycles(exec_cycles), .bus_value(bus_value), .done(done), .status(status),
    .slot(slot), .sel_instr_tag(sel_instr_tag), .sel_src1(sel_src1),
    .sel_src2(sel_src2), .sel_rob_tag(sel_rob_tag), .last(last)
  );

  always #5 clk = ~clk;

  station_t table_q[$];
  beat_t expected_beats[$];
  int errors = 0;
  int beats_seen = 0;
  int ops_sent = 0;
  int idle_pct = 0;

  function automatic beat_t plain_beat(logic [1:0] st, logic [2:0] sl);
    beat_t b;
    b = '0;
    b.status = st;
    b.slot = sl;
    b.last = 1'b1;
    return b;
  endfunction

  function automatic int find_rob(logic [3:0] tag);
    for (int i = 0; i < table_q.size(); i++) begin
      if (table_q[i].rob == tag) return i;
    end
    return -1;
  endfunction

  task automatic add_expected(input beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endtask

  task automatic predict_station(input logic [2:0] op, input logic [7:0] it,
                                 input logic [31:0] v1, input logic [31:0] v2,
                                 input logic w1, input logic [3:0] t1,
                                 input logic w2, input logic [3:0] t2,
                                 input logic [3:0] rt, input logic [15:0] now,
                                 input logic [7:0] ec, input logic [31:0] bv);
    station_t s;
    beat_t b;
    int pos;
    int n;
    n = 0;
    case (op)
      OP_DISPATCH: begin
        if (table_q.size() >= NSTAT) begin
          add_expected(plain_beat(ST_FULL, 3'd0));
        end else begin
          s = '{it, v1, v2, w1, t1, w2, t2, rt, now, ec};
          add_expected(plain_beat(ST_OK, 3'(table_q.size())));
          table_q.insert(table_q.size(), s);
        end
      end
      OP_BROADCAST: begin
        foreach (table_q[i]) begin
          if (table_q[i].wait1 && table_q[i].tag1 == rt) begin
            table_q[i].val1 = bv;
            table_q[i].wait1 = 1'b0;
          end
          if (table_q[i].wait2 && table_q[i].tag2 == rt) begin
            table_q[i].val2 = bv;
            table_q[i].wait2 = 1'b0;
          end
        end
        add_expected(plain_beat(ST_OK, 3'd0));
      end
      OP_SELECT: begin
        foreach (table_q[i]) begin
          if (!table_q[i].wait1 && !table_q[i].wait2 && table_q[i].cyc < now &&
              table_q[i].left > 0) begin
            b = '{ST_OK, i[2:0], table_q[i].instr, table_q[i].val1, table_q[i].val2,
                  table_q[i].rob, 1'b0};
            add_expected(b);
            n++;
          end
        end
        if (n == 0) add_expected(plain_beat(ST_NONE, 3'd0));
        else expected_beats[$].last = 1'b1;
      end
      OP_REMOVE, OP_EXECUTE: begin
        pos = find_rob(rt);
        if (pos < 0) begin
          add_expected(plain_beat(ST_NOTAG, 3'd0));
        end else begin
          if (op == OP_REMOVE) table_q.delete(pos);
          else if (table_q[pos].left > 0) table_q[pos].left--;
          add_expected(plain_beat(ST_OK, 3'(pos)));
        end
      end
      default: add_expected(plain_beat(ST_OK, 3'd0));
    endcase
  endtask

  always @(posedge clk) begin
    beat_t e;
    if (!rst && done) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat status=%0d slot=%0d", status, slot);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status); errors++;
        end
        if (slot !== e.slot) begin
          $error("slot expected %0d actual %0d", e.slot, slot); errors++;
        end
        if (sel_instr_tag !== e.instr) begin
          $error("sel_instr_tag expected %0h actual %0h", e.instr, sel_instr_tag); errors++;
        end
        if (sel_src1 !== e.src1) begin
          $error("sel_src1 expected %0h actual %0h", e.src1, sel_src1); errors++;
        end
        if (sel_src2 !== e.src2) begin
          $error("sel_src2 expected %0h actual %0h", e.src2, sel_src2); errors++;
        end
        if (sel_rob_tag !== e.rob) begin
          $error("sel_rob_tag expected %0h actual %0h", e.rob, sel_rob_tag); errors++;
        end
        if (last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, last); errors++;
        end
      end
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [7:0] it,
                         input logic [31:0] v1, input logic [31:0] v2,
                         input logic w1, input logic [3:0] t1,
                         input logic w2, input logic [3:0] t2,
                         input logic [3:0] rt, input logic [15:0] now,
                         input logic [7:0] ec, input logic [31:0] bv);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    operation <= op; instr_tag <= it; src1_value <= v1; src2_value <= v2;
    src1_waiting <= w1; src1_tag <= t1; src2_waiting <= w2; src2_tag <= t2;
    rob_tag <= rt; cycle_now <= now; exec_cycles <= ec; bus_value <= bv;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_station(op, it, v1, v2, w1, t1, w2, t2, rt, now, ec, bv);
    ops_sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random;
    int r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < 30) op = OP_DISPATCH;
    else if (r < 50) op = OP_BROADCAST;
    else if (r < 70) op = OP_SELECT;
    else if (r < 82) op = OP_REMOVE;
    else if (r < 97) op = OP_EXECUTE;
    else op = 3'($urandom_range(7, 5));
    send_op(op, 8'($urandom), $urandom, $urandom, 1'($urandom), 4'($urandom_range(3)),
            1'($urandom), 4'($urandom_range(3)),
            ((op == OP_REMOVE || op == OP_EXECUTE) && table_q.size() > 0 && $urandom_range(3) != 0)
              ? table_q[$urandom_range(table_q.size() - 1)].rob
              : 4'($urandom),
            ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
            ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(3)), $urandom);
  endtask

  task automatic drain;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic test_directed;
    send_op(OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 16'hffff, 0, 0);
    send_op(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 4'd5, 0, 0, 0);
    send_op(OP_EXECUTE, 0, 0, 0, 0, 0, 0, 0, 4'd5, 0, 0, 0);
    send_op(OP_DISPATCH, 8'hff, 32'h7fffffff, 32'h80000000, 0, 4'hf, 0, 4'hf, 4'd5,
            16'd0, 8'hff, 0);
    send_op(OP_DISPATCH, 8'h00, 32'hffffffff, 0, 1, 4'd3, 1, 4'd3, 4'd5, 16'hfffe, 8'd1, 0);
    send_op(OP_DISPATCH, 8'h5a, 0, 0, 1, 4'hf, 0, 4'd2, 4'd15, 16'd1, 8'd0, 0);
    send_op(OP_BROADCAST, 0, 0, 0, 0, 0, 0, 0, 4'd9, 0, 0, 32'hdeadbeef);
    send_op(OP_BROADCAST, 0, 0, 0, 0, 0, 0, 0, 4'd3, 0, 0, 32'h80000000);
    send_op(OP_BROADCAST, 0, 0, 0, 0, 0, 0, 0, 4'hf, 0, 0, 32'h7fffffff);
    send_op(OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 16'hffff, 0, 0);
    send_op(OP_EXECUTE, 0, 0, 0, 0, 0, 0, 0, 4'd5, 0, 0, 0);
    send_op(OP_EXECUTE, 0, 0, 0, 0, 0, 0, 0, 4'd15, 0, 0, 0);
    send_op(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 4'd5, 0, 0, 0);
    for (int i = 0; i < 7; i++)
      send_op(OP_DISPATCH, 8'(i), 32'(i), 32'(-i), 0, 0, 0, 0, 4'(i), 16'(i), 8'd2, 0);
    send_op(OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 16'd100, 0, 0);
    send_op(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(3'd7, 8'hff, '1, '1, 1, '1, 1, '1, '1, '1, '1, '1);
    drain();
  endtask

  task automatic test_random(input int pct, input int count);
    idle_pct = pct;
    repeat (count) send_random();
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 80);
    test_random(58, 80);
    test_random(0, 70);
    test_random(15, 70);
    $display("Sent %0d operations across four idle phases; checked %0d result beats.",
             ops_sent, beats_seen);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/rst_pkg.sv
design/rst_ctrl.sv
design/rst_dp.sv
design/reservation_station_table_core.sv
design/rst_checker.sv
tb/reservation_station_table_core_tb.sv
